// ----- rtl/mexp_pkg.sv -----
// Shared types and constants for the modular exponentiation core.
`timescale 1ns / 1ps

package mexp_pkg;

    // Operand width of base, exponent, modulus and result
    localparam int OPERAND_WIDTH = 31;
    // Bit counter of the serial multiplier; holds OPERAND_WIDTH - 1
    localparam int CNT_W = $clog2(OPERAND_WIDTH);
    // Working width of the multiplier datapath: sum below 3 * 2^W plus a sign bit
    localparam int EXT_W = OPERAND_WIDTH + 3;

    typedef logic [OPERAND_WIDTH-1:0] opnd_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [EXT_W-1:0]         ext_t;

    localparam opnd_t OPND_ZERO = opnd_t'(0);
    localparam opnd_t OPND_ONE  = opnd_t'(1);
    localparam opnd_t OPND_TWO  = opnd_t'(2);

    // Request to the serial modular multiplier
    typedef struct packed {
        logic  start;
        opnd_t a;
        opnd_t b;
    } mul_req_t;

    // Response from the serial modular multiplier
    typedef struct packed {
        logic  done;
        opnd_t product;
    } mul_rsp_t;

    // Sequencer states of the top level
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RED  = 5'b00010,
        ST_STEP = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_SQR  = 5'b10000
    } state_t;

endpackage

// ----- rtl/mexp_mul.sv -----
// Bit-serial modular multiplier: (a * b) mod m, one bit of b per cycle, MSB first.
`timescale 1ns / 1ps

module mexp_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_pkg::mul_req_t req,
    input  mexp_pkg::opnd_t    m,
    output mexp_pkg::mul_rsp_t rsp
);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    mexp_pkg::cnt_t  cnt_reg, cnt_next;
    mexp_pkg::opnd_t acc_reg, acc_next;
    mexp_pkg::opnd_t a_reg, a_next;
    mexp_pkg::opnd_t b_reg, b_next;

    mexp_pkg::ext_t  sum;
    mexp_pkg::ext_t  diff1;
    mexp_pkg::ext_t  diff2;
    mexp_pkg::opnd_t acc_step;

    // One step: acc = (2*acc + bit*a) mod m, with both reductions tried in parallel
    always_comb
    begin
        sum   = (mexp_pkg::ext_t'(acc_reg) << 1)
              + (b_reg[mexp_pkg::OPERAND_WIDTH-1] ? mexp_pkg::ext_t'(a_reg) : '0);
        diff1 = sum - mexp_pkg::ext_t'(m);
        diff2 = sum - (mexp_pkg::ext_t'(m) << 1);
        if (!diff2[mexp_pkg::EXT_W-1])
        begin
            acc_step = diff2[mexp_pkg::OPERAND_WIDTH-1:0];
        end
        else if (!diff1[mexp_pkg::EXT_W-1])
        begin
            acc_step = diff1[mexp_pkg::OPERAND_WIDTH-1:0];
        end
        else
        begin
            acc_step = sum[mexp_pkg::OPERAND_WIDTH-1:0];
        end
    end

    // Load on start, then shift b out one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mexp_pkg::cnt_t'(mexp_pkg::OPERAND_WIDTH - 1);
            acc_next  = mexp_pkg::OPND_ZERO;
            a_next    = req.a;
            b_next    = req.b;
        end
        else if (busy_reg)
        begin
            acc_next = acc_step;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - mexp_pkg::cnt_t'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ----- rtl/modular_exponentiation_core.sv -----
// Top level: modular exponentiation by right-to-left square and multiply.
//
// Usage:
//   Input: an item is taken at a rising edge with start high and busy low.
//   func = 0 computes base_value ^ exponent_value mod modulus_value;
//   func = 1 uses modulus_value - 2 as exponent (Fermat inverse for a prime).
//   Output: result_value is valid for exactly one cycle while done is high;
//   the receiver cannot stall, so it must take the item in that cycle.
//   Flow: a modulus of zero answers 0 in the cycle after the item is taken.
//   Otherwise the base is first reduced, then each exponent bit up to the
//   highest set one costs one square and, for a set bit, one multiply, each
//   in the shared bit-serial multiplier; the highest set bit needs no square.
//   One item is in work at a time and busy stays high until done.
//   A base that reduces to zero ends right after the reduction with result 0.
//   Reset: asynchronous, active low; the block returns to idle, no item and
//   no result pending.
`timescale 1ns / 1ps

module modular_exponentiation_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      func,
    input  logic [mexp_pkg::OPERAND_WIDTH-1:0] base_value,
    input  logic [mexp_pkg::OPERAND_WIDTH-1:0] exponent_value,
    input  logic [mexp_pkg::OPERAND_WIDTH-1:0] modulus_value,
    output logic                      done,
    output logic [mexp_pkg::OPERAND_WIDTH-1:0] result_value
);

    mexp_pkg::state_t   state_reg, state_next;
    mexp_pkg::opnd_t    m_reg, m_next;
    mexp_pkg::opnd_t    e_reg, e_next;
    mexp_pkg::opnd_t    acc_reg, acc_next;
    mexp_pkg::opnd_t    sq_reg, sq_next;
    mexp_pkg::opnd_t    result_reg, result_next;
    logic               done_reg, done_next;

    mexp_pkg::mul_req_t mul_req;
    mexp_pkg::mul_rsp_t mul_rsp;

    // Shared serial multiplier
    mexp_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .m     (m_reg),
        .rsp   (mul_rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        e_next      = e_reg;
        acc_next    = acc_reg;
        sq_next     = sq_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mul_req     = '0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    m_next = modulus_value;
                    if (func)
                    begin
                        e_next = (modulus_value >= mexp_pkg::OPND_TWO)
                               ? (modulus_value - mexp_pkg::OPND_TWO)
                               : mexp_pkg::OPND_ZERO;
                    end
                    else
                    begin
                        e_next = exponent_value;
                    end
                    if (modulus_value == mexp_pkg::OPND_ZERO)
                    begin
                        result_next = mexp_pkg::OPND_ZERO;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // base mod m computed as (1 * base) mod m
                        mul_req.start = 1'b1;
                        mul_req.a     = mexp_pkg::OPND_ONE;
                        mul_req.b     = base_value;
                        state_next    = mexp_pkg::ST_RED;
                    end
                end
            end
            mexp_pkg::ST_RED:
            begin
                if (mul_rsp.done)
                begin
                    sq_next  = mul_rsp.product;
                    acc_next = mexp_pkg::OPND_ONE;
                    if (mul_rsp.product == mexp_pkg::OPND_ZERO)
                    begin
                        result_next = mexp_pkg::OPND_ZERO;
                        done_next   = 1'b1;
                        state_next  = mexp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_STEP;
                    end
                end
            end
            mexp_pkg::ST_STEP:
            begin
                // Remaining exponent bits zero: nothing more changes acc
                if (e_reg == mexp_pkg::OPND_ZERO)
                begin
                    result_next = acc_reg;
                    done_next   = 1'b1;
                    state_next  = mexp_pkg::ST_IDLE;
                end
                else if (e_reg[0])
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = acc_reg;
                    mul_req.b     = sq_reg;
                    state_next    = mexp_pkg::ST_MUL;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = sq_reg;
                    mul_req.b     = sq_reg;
                    state_next    = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    acc_next   = mul_rsp.product;
                    e_next     = {e_reg[mexp_pkg::OPERAND_WIDTH-1:1], 1'b0};
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_SQR:
            begin
                if (mul_rsp.done)
                begin
                    sq_next    = mul_rsp.product;
                    e_next     = e_reg >> 1;
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != mexp_pkg::ST_IDLE);
    assign done         = done_reg;
    assign result_value = result_reg;

endmodule

// ----- rtl/mexp_check.sv -----
// Port-level checker for the modular exponentiation core, with its bind.
`timescale 1ns / 1ps

module mexp_check
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [mexp_pkg::OPERAND_WIDTH-1:0] modulus_value,
    input logic                               done,
    input logic [mexp_pkg::OPERAND_WIDTH-1:0] result_value
);

    // A result is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // Every end of work delivers a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without a result");

    // A nonzero modulus starts real work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && modulus_value != '0) |=> (busy && !done))
        else $error("item taken but block not busy");

    // A zero modulus answers zero at once
    a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && modulus_value == '0) |=>
            (done && !busy && result_value == '0))
        else $error("zero modulus not answered with zero");

endmodule

bind modular_exponentiation_core mexp_check u_mexp_check (.*);
